@@ hw/rtl/smq_pkg.sv @@
// Shared types and constants for the sliding minimum queue.
// Used by the channel interfaces, the sequencer and the top level.
package smq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 64;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int FIELD_VALUE_W  = 32;
   localparam int FIELD_OFFSET_W = 6;
   localparam int FIELD_COUNT_W  = 7;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   typedef struct packed {
      logic [FIELD_VALUE_W-1:0]  min_value;
      logic [FIELD_OFFSET_W-1:0] min_offset;
      logic [FIELD_COUNT_W-1:0]  candidate_count;
      logic [FIELD_COUNT_W-1:0]  queue_count;
      logic [FIELD_VALUE_W-1:0]  newest_value;
      logic                      is_empty;
      logic                      overflow;
   } status_type;

endpackage

@@ hw/rtl/smq_req_if.sv @@
// Request channel of the sliding minimum queue: operation and value.
// Depends on smq_pkg for the field widths.
interface smq_req_if;
   import smq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic [FIELD_VALUE_W-1:0] value;

   modport source (output valid, output operation, output value, input ready);
   modport sink (input valid, input operation, input value, output ready);
endinterface

@@ hw/rtl/smq_rsp_if.sv @@
// Response channel of the sliding minimum queue: one status record per request.
// Depends on smq_pkg for the field widths.
interface smq_rsp_if;
   import smq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [FIELD_VALUE_W-1:0]  min_value;
   logic [FIELD_OFFSET_W-1:0] min_offset;
   logic [FIELD_COUNT_W-1:0]  candidate_count;
   logic [FIELD_COUNT_W-1:0]  queue_count;
   logic [FIELD_VALUE_W-1:0]  newest_value;
   logic                      is_empty;
   logic                      overflow;

   modport source (output valid, output min_value, output min_offset,
                   output candidate_count, output queue_count, output newest_value,
                   output is_empty, output overflow, input ready);
   modport sink (input valid, input min_value, input min_offset,
                 input candidate_count, input queue_count, input newest_value,
                 input is_empty, input overflow, output ready);
endinterface

@@ hw/rtl/smq_ring.sv @@
// Ring storage with one write port and one registered read port.
// Holds either the value ring or the candidate ring; no dependencies.
module smq_ring #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 32,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/smq_ctrl.sv @@
// Sequencer of the sliding minimum queue: pointers, candidate scan and status.
// Drives the two smq_ring stores and uses status_type from smq_pkg.
module smq_ctrl #(
   parameter int QUEUE_DEPTH = smq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = smq_pkg::VALUE_WIDTH_DEFAULT,
   parameter int IDX_W       = $clog2(QUEUE_DEPTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_operation,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   done,
   input  logic                   out_free,
   output smq_pkg::status_type    status,
   output logic                   val_wr_en,
   output logic [IDX_W-1:0]       val_wr_addr,
   output logic [VALUE_WIDTH-1:0] val_wr_data,
   output logic                   val_rd_en,
   output logic [IDX_W-1:0]       val_rd_addr,
   input  logic [VALUE_WIDTH-1:0] val_rd_data,
   output logic                   cand_wr_en,
   output logic [IDX_W-1:0]       cand_wr_addr,
   output logic [IDX_W-1:0]       cand_wr_data,
   output logic                   cand_rd_en,
   output logic [IDX_W-1:0]       cand_rd_addr,
   input  logic [IDX_W-1:0]       cand_rd_data
);
   import smq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_SLOT,
      ST_SCAN_CMP,
      ST_PUSH,
      ST_FRONT,
      ST_FRONT_SLOT,
      ST_FRONT_VAL,
      ST_DONE
   } state_type;

   state_type              state_ff;
   logic [IDX_W-1:0]       vh_ff;
   logic [CNT_W-1:0]       vc_ff;
   logic [IDX_W-1:0]       ch_ff;
   logic [CNT_W-1:0]       cc_ff;
   logic [VALUE_WIDTH-1:0] operand_ff;
   logic [IDX_W-1:0]       slot_ff;
   logic [IDX_W-1:0]       front_ff;
   logic [VALUE_WIDTH-1:0] min_ff;
   logic [VALUE_WIDTH-1:0] newest_ff;
   logic                   overflow_ff;

   logic [IDX_W-1:0] tail_idx;
   logic [IDX_W-1:0] back_idx;
   logic [IDX_W-1:0] push_idx;
   logic [IDX_W-1:0] offset_idx;
   logic             full;
   logic             empty;
   logic             have_min;
   logic             accept;

   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
      if (sum >= DEPTH_EXT) begin
         sum = sum - DEPTH_EXT;
      end
      return sum[IDX_W-1:0];
   endfunction

   assign tail_idx   = ring_add(vh_ff, vc_ff);
   assign back_idx   = ring_add(ch_ff, cc_ff - ONE_CNT);
   assign push_idx   = ring_add(ch_ff, cc_ff);
   assign offset_idx = ring_add(front_ff, DEPTH_CNT - CNT_W'(vh_ff));
   assign full       = (vc_ff == DEPTH_CNT);
   assign empty      = (vc_ff == '0);
   assign have_min   = !empty && (cc_ff != '0);

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign done      = (state_ff == ST_DONE);

   assign val_wr_en    = accept && (req_operation == OP_ENQUEUE) && !full;
   assign val_wr_addr  = tail_idx;
   assign val_wr_data  = req_value;
   assign val_rd_en    = (state_ff == ST_SCAN_SLOT) || (state_ff == ST_FRONT_SLOT);
   assign val_rd_addr  = cand_rd_data;
   assign cand_wr_en   = (state_ff == ST_PUSH);
   assign cand_wr_addr = push_idx;
   assign cand_wr_data = slot_ff;
   assign cand_rd_en   = ((state_ff == ST_SCAN) && (cc_ff != '0)) || (state_ff == ST_FRONT);
   assign cand_rd_addr = (state_ff == ST_FRONT) ? ch_ff : back_idx;

   always_comb begin
      status.min_value       = have_min ? FIELD_VALUE_W'(min_ff) : '0;
      status.min_offset      = have_min ? FIELD_OFFSET_W'(offset_idx) : '0;
      status.candidate_count = FIELD_COUNT_W'(cc_ff);
      status.queue_count     = FIELD_COUNT_W'(vc_ff);
      status.newest_value    = empty ? '0 : FIELD_VALUE_W'(newest_ff);
      status.is_empty        = empty;
      status.overflow        = overflow_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vh_ff    <= '0;
         vc_ff    <= '0;
         ch_ff    <= '0;
         cc_ff    <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  overflow_ff <= 1'b0;
                  if (req_operation == OP_ENQUEUE) begin
                     if (full) begin
                        overflow_ff <= 1'b1;
                        state_ff    <= ST_DONE;
                     end else begin
                        operand_ff <= req_value;
                        newest_ff  <= req_value;
                        slot_ff    <= tail_idx;
                        vc_ff      <= vc_ff + ONE_CNT;
                        state_ff   <= ST_SCAN;
                     end
                  end else if (empty) begin
                     state_ff <= ST_DONE;
                  end else begin
                     if ((cc_ff != '0) && (front_ff == vh_ff)) begin
                        ch_ff <= ring_add(ch_ff, ONE_CNT);
                        cc_ff <= cc_ff - ONE_CNT;
                     end
                     vh_ff    <= ring_add(vh_ff, ONE_CNT);
                     vc_ff    <= vc_ff - ONE_CNT;
                     state_ff <= ST_FRONT;
                  end
               end
            end
            ST_SCAN: begin
               state_ff <= (cc_ff == '0) ? ST_PUSH : ST_SCAN_SLOT;
            end
            ST_SCAN_SLOT: begin
               state_ff <= ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
               if (val_rd_data > operand_ff) begin
                  cc_ff    <= cc_ff - ONE_CNT;
                  state_ff <= ST_SCAN;
               end else begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               cc_ff    <= cc_ff + ONE_CNT;
               state_ff <= ST_FRONT;
            end
            ST_FRONT: begin
               state_ff <= (cc_ff == '0) ? ST_DONE : ST_FRONT_SLOT;
            end
            ST_FRONT_SLOT: begin
               front_ff <= cand_rd_data;
               state_ff <= ST_FRONT_VAL;
            end
            ST_FRONT_VAL: begin
               min_ff   <= val_rd_data;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ hw/rtl/sliding_min_queue_unit.sv @@
// Top level of the sliding minimum queue: channel ports and response register.
// Depends on smq_pkg, smq_req_if, smq_rsp_if, smq_ring and smq_ctrl.
//
// A FIFO of unsigned values that reports its minimum after every request. Each
// request on req_ch (enqueue or dequeue) gives exactly one status record on rsp_ch.
// The block takes one request at a time; both rings have a single read port, so
// each candidate examined costs a candidate read, a value read and a compare.
// An enqueue compares candidates from the back, dropping each larger value, pushes
// its slot and reads the new front candidate and its value; a dequeue reads the
// front again unless no candidate is left; a dropped enqueue on a full queue or a
// dequeue of an empty queue goes straight to the status. A finished status waits
// in the response register, and the next request is taken while it waits. Ring
// contents need no clearing after reset.
module sliding_min_queue_unit #(
   parameter int QUEUE_DEPTH = smq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = smq_pkg::VALUE_WIDTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   smq_req_if.sink   req_ch,
   smq_rsp_if.source rsp_ch
);
   import smq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   logic                   done;
   logic                   out_free;
   status_type             status;
   status_type             rsp_data_ff;
   logic                   rsp_valid_ff;
   logic                   val_wr_en;
   logic [IDX_W-1:0]       val_wr_addr;
   logic [VALUE_WIDTH-1:0] val_wr_data;
   logic                   val_rd_en;
   logic [IDX_W-1:0]       val_rd_addr;
   logic [VALUE_WIDTH-1:0] val_rd_data;
   logic                   cand_wr_en;
   logic [IDX_W-1:0]       cand_wr_addr;
   logic [IDX_W-1:0]       cand_wr_data;
   logic                   cand_rd_en;
   logic [IDX_W-1:0]       cand_rd_addr;
   logic [IDX_W-1:0]       cand_rd_data;

   smq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX_W       (IDX_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_operation (req_ch.operation),
      .req_value     (VALUE_WIDTH'(req_ch.value)),
      .done          (done),
      .out_free      (out_free),
      .status        (status),
      .val_wr_en     (val_wr_en),
      .val_wr_addr   (val_wr_addr),
      .val_wr_data   (val_wr_data),
      .val_rd_en     (val_rd_en),
      .val_rd_addr   (val_rd_addr),
      .val_rd_data   (val_rd_data),
      .cand_wr_en    (cand_wr_en),
      .cand_wr_addr  (cand_wr_addr),
      .cand_wr_data  (cand_wr_data),
      .cand_rd_en    (cand_rd_en),
      .cand_rd_addr  (cand_rd_addr),
      .cand_rd_data  (cand_rd_data)
   );

   smq_ring #(
      .DEPTH  (QUEUE_DEPTH),
      .DATA_W (VALUE_WIDTH),
      .ADDR_W (IDX_W)
   ) u_value_ring (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (val_wr_data),
      .rd_en   (val_rd_en),
      .rd_addr (val_rd_addr),
      .rd_data (val_rd_data)
   );

   smq_ring #(
      .DEPTH  (QUEUE_DEPTH),
      .DATA_W (IDX_W),
      .ADDR_W (IDX_W)
   ) u_cand_ring (
      .clock   (clock),
      .wr_en   (cand_wr_en),
      .wr_addr (cand_wr_addr),
      .wr_data (cand_wr_data),
      .rd_en   (cand_rd_en),
      .rd_addr (cand_rd_addr),
      .rd_data (cand_rd_data)
   );

   // The response register is free when empty or when its transfer completes now.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= done;
      end
      if (done && out_free) begin
         rsp_data_ff <= status;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.min_value       = rsp_data_ff.min_value;
   assign rsp_ch.min_offset      = rsp_data_ff.min_offset;
   assign rsp_ch.candidate_count = rsp_data_ff.candidate_count;
   assign rsp_ch.queue_count     = rsp_data_ff.queue_count;
   assign rsp_ch.newest_value    = rsp_data_ff.newest_value;
   assign rsp_ch.is_empty        = rsp_data_ff.is_empty;
   assign rsp_ch.overflow        = rsp_data_ff.overflow;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for sliding_min_queue_unit: directed and random transfers
// checked against an in-bench model of the minimum queue. Needs smq_pkg and the
// channel interfaces smq_req_if and smq_rsp_if.
`timescale 1ns / 1ps

module testbench;
   import smq_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH_DEFAULT;
   localparam int PRED_DEPTH = 16;
   localparam logic [FIELD_VALUE_W-1:0] VALUE_MAX = '1;

   typedef enum int {VAL_FULL, VAL_TINY, VAL_HIGH, VAL_EXTREME, VAL_FALLING} value_mode_type;

   logic clock = 1'b0;
   logic reset;

   smq_req_if req_ch ();
   smq_rsp_if rsp_ch ();

   sliding_min_queue_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #2 clock = ~clock;

   // Model state of the value FIFO and the candidate queue.
   logic [FIELD_VALUE_W-1:0] held_values [DEPTH];
   int                       cand_slots [DEPTH];
   int                       held_head;
   int                       held_count;
   int                       cand_head;
   int                       cand_count;

   status_type predicted [PRED_DEPTH];
   int         pred_wr_count = 0;
   int         pred_rd_count = 0;
   int         send_idle_pct;
   int         recv_stall_pct;
   int         error_count = 0;
   int         items_sent;
   int         results_checked = 0;
   int         overflow_seen = 0;
   int         full_seen;
   logic [FIELD_VALUE_W-1:0] falling_value;

   function automatic status_type predict_status(logic op, logic [FIELD_VALUE_W-1:0] val);
      status_type s;
      int         slot;
      int         min_slot;
      s = '0;
      if (op == OP_ENQUEUE) begin
         if (held_count >= DEPTH) begin
            s.overflow = 1'b1;
         end else begin
            slot = (held_head + held_count) % DEPTH;
            held_values[slot] = val;
            held_count++;
            while (cand_count > 0 &&
                   held_values[cand_slots[(cand_head + cand_count - 1) % DEPTH]] > val)
               cand_count--;
            cand_slots[(cand_head + cand_count) % DEPTH] = slot;
            cand_count++;
         end
      end else if (held_count > 0) begin
         if (cand_count > 0 && cand_slots[cand_head] == held_head) begin
            cand_head = (cand_head + 1) % DEPTH;
            cand_count--;
         end
         held_head = (held_head + 1) % DEPTH;
         held_count--;
      end
      if (held_count > 0 && cand_count > 0) begin
         min_slot = cand_slots[cand_head];
         s.min_value = held_values[min_slot];
         s.min_offset = FIELD_OFFSET_W'((min_slot + DEPTH - held_head) % DEPTH);
         s.newest_value = held_values[(held_head + held_count - 1) % DEPTH];
      end
      s.candidate_count = FIELD_COUNT_W'(cand_count);
      s.queue_count = FIELD_COUNT_W'(held_count);
      s.is_empty = (held_count == 0);
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic send_item(input logic op, input logic [FIELD_VALUE_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.value <= val;
      predicted[pred_wr_count % PRED_DEPTH] = predict_status(op, val);
      pred_wr_count++;
      if (held_count == DEPTH)
         full_seen++;
      items_sent++;
      do
         @(posedge clock);
      while (!req_ch.ready);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pred_wr_count != pred_rd_count)
         @(posedge clock);
   endtask

   // Each completed transfer on the result channel is checked against the oldest prediction.
   always @(posedge clock) begin
      status_type got;
      status_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.min_value = rsp_ch.min_value;
            got.min_offset = rsp_ch.min_offset;
            got.candidate_count = rsp_ch.candidate_count;
            got.queue_count = rsp_ch.queue_count;
            got.newest_value = rsp_ch.newest_value;
            got.is_empty = rsp_ch.is_empty;
            got.overflow = rsp_ch.overflow;
            if (pred_wr_count == pred_rd_count) begin
               report_mismatch("unexpected result, queue_count", 64'(got.queue_count),
                               64'(0));
            end else begin
               want = predicted[pred_rd_count % PRED_DEPTH];
               pred_rd_count++;
               results_checked++;
               if (want.overflow)
                  overflow_seen++;
               if (got.min_value !== want.min_value)
                  report_mismatch("min_value", 64'(got.min_value), 64'(want.min_value));
               if (got.min_offset !== want.min_offset)
                  report_mismatch("min_offset", 64'(got.min_offset), 64'(want.min_offset));
               if (got.candidate_count !== want.candidate_count)
                  report_mismatch("candidate_count", 64'(got.candidate_count),
                                  64'(want.candidate_count));
               if (got.queue_count !== want.queue_count)
                  report_mismatch("queue_count", 64'(got.queue_count),
                                  64'(want.queue_count));
               if (got.newest_value !== want.newest_value)
                  report_mismatch("newest_value", 64'(got.newest_value),
                                  64'(want.newest_value));
               if (got.is_empty !== want.is_empty)
                  report_mismatch("is_empty", 64'(got.is_empty), 64'(want.is_empty));
               if (got.overflow !== want.overflow)
                  report_mismatch("overflow", 64'(got.overflow), 64'(want.overflow));
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [FIELD_VALUE_W-1:0] pick_value(value_mode_type mode);
      case (mode)
         VAL_TINY:    return FIELD_VALUE_W'($urandom_range(7));
         VAL_HIGH:    return VALUE_MAX - FIELD_VALUE_W'($urandom_range(7));
         VAL_EXTREME: return $urandom_range(1) ? VALUE_MAX : '0;
         VAL_FALLING: begin
            falling_value = falling_value - FIELD_VALUE_W'($urandom_range(3));
            return falling_value;
         end
         default:     return $urandom;
      endcase
   endfunction

   task automatic test_basic_operations();
      send_item(OP_DEQUEUE, 32'hDEAD_BEEF);
      send_item(OP_ENQUEUE, 32'h0000_0000);
      send_item(OP_ENQUEUE, VALUE_MAX);
      send_item(OP_ENQUEUE, VALUE_MAX);
      send_item(OP_ENQUEUE, 32'h0000_0005);
      send_item(OP_ENQUEUE, 32'h0000_0005);
      send_item(OP_DEQUEUE, VALUE_MAX);
      send_item(OP_ENQUEUE, 32'h0000_0003);
      send_item(OP_DEQUEUE, 32'h0);
      send_item(OP_DEQUEUE, 32'h0);
      send_item(OP_DEQUEUE, 32'h0);
      send_item(OP_DEQUEUE, 32'h0);
      send_item(OP_DEQUEUE, 32'h0);
      send_item(OP_DEQUEUE, 32'h0);
      send_item(OP_ENQUEUE, 32'hAAAA_5555);
      send_item(OP_ENQUEUE, 32'h5555_AAAA);
      send_item(OP_ENQUEUE, 32'h8000_0001);
      send_item(OP_ENQUEUE, 32'h7FFF_FFFF);
      send_item(OP_ENQUEUE, 32'h0000_0001);
      send_item(OP_DEQUEUE, 32'h0);
      send_item(OP_DEQUEUE, 32'h0);
      send_item(OP_DEQUEUE, 32'h0);
      send_item(OP_DEQUEUE, 32'h0);
      send_item(OP_DEQUEUE, 32'h0);
      send_item(OP_DEQUEUE, 32'h0);
   endtask

   // Rising values keep every element as a candidate, so the zero that follows one
   // dequeue must drop all remaining candidates; enqueues on the full FIFO are rejected.
   task automatic test_full_queue();
      for (int i = 0; i < DEPTH; i++)
         send_item(OP_ENQUEUE, FIELD_VALUE_W'(i + 1));
      send_item(OP_ENQUEUE, 32'h0);
      send_item(OP_DEQUEUE, 32'h0);
      send_item(OP_ENQUEUE, 32'h0);
      send_item(OP_ENQUEUE, $urandom);
      for (int i = 0; i <= DEPTH; i++)
         send_item(OP_DEQUEUE, $urandom);
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      int             enqueue_pct;
      int             burst;
      value_mode_type mode;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      while (count > 0) begin
         case ($urandom_range(2))
            0:       enqueue_pct = 85;
            1:       enqueue_pct = 50;
            default: enqueue_pct = 20;
         endcase
         mode = value_mode_type'($urandom_range(4));
         falling_value = $urandom;
         burst = $urandom_range(10, 70);
         for (int i = 0; i < burst && count > 0; i++) begin
            send_item(($urandom_range(99) < enqueue_pct) ? OP_ENQUEUE : OP_DEQUEUE,
                      pick_value(mode));
            count--;
         end
      end
      wait_drained();
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.operation <= OP_ENQUEUE;
      req_ch.value <= '0;
      held_head = 0;
      held_count = 0;
      cand_head = 0;
      cand_count = 0;
      items_sent = 0;
      full_seen = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_basic_operations();
      wait_drained();
      test_full_queue();
      wait_drained();
      test_random_traffic(160, 0, 0);
      test_random_traffic(160, 88, 0);
      test_random_traffic(160, 0, 88);
      test_random_traffic(160, 38, 38);

      repeat (300) @(posedge clock);
      $display("Covered %0d transfers with %0d results checked, %0d rejected enqueues,",
               items_sent, results_checked, overflow_seen);
      $display("%0d transfers at full depth, across four sender and receiver idle patterns.",
               full_seen);
      if (error_count == 0) begin
         $display("sliding_min_queue_unit: match");
      end else begin
         $display("sliding_min_queue_unit: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d results outstanding.", pred_wr_count - pred_rd_count);
      $display("sliding_min_queue_unit: mismatch");
      $finish;
   end

endmodule
